### hw/rtl/owtr_pkg.sv
// Shared types and constants for the one-wire temperature reader.
package owtr_pkg;

  localparam int READ_BITS_DEFAULT = 16;

  // Configuration register indexes
  localparam logic [7:0] CFG_SKIP_ROM  = 8'd0;
  localparam logic [7:0] CFG_CONVERT   = 8'd1;
  localparam logic [7:0] CFG_READ      = 8'd2;
  localparam logic [7:0] CFG_CONV_WAIT = 8'd3;

  localparam logic [7:0]  SKIP_ROM_RESET  = 8'd204;
  localparam logic [7:0]  CONVERT_RESET   = 8'd68;
  localparam logic [7:0]  READ_CMD_RESET  = 8'd190;
  localparam logic [19:0] CONV_WAIT_RESET = 20'd750000;

  // Bus timing in microseconds
  localparam logic [19:0] RESET_LOW_US = 20'd480;
  localparam logic [19:0] RESET_REL_US = 20'd240;
  localparam logic [19:0] WSLOT_US     = 20'd61;
  localparam logic [19:0] W0_LOW_US    = 20'd60;
  localparam logic [19:0] W1_LOW_US    = 20'd5;
  localparam logic [19:0] RSLOT_US     = 20'd60;
  localparam logic [19:0] R_LOW_US     = 20'd5;
  localparam logic [19:0] R_SAMPLE_US  = 20'd15;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [7:0]  skip_rom_command;
    logic [7:0]  convert_command;
    logic [7:0]  read_command;
    logic [19:0] conversion_wait_us;
  } owtr_cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence_seen;
    logic [15:0] raw_reading;
    logic        negative;
    logic [11:0] whole_degrees;
  } owtr_result_t;

endpackage

### hw/rtl/owtr_seq.sv
// Bus sequencer: sequence state and its per-item update.
module owtr_seq #(
  parameter int READ_BITS = owtr_pkg::READ_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  cmd,
  input  logic                  bus_level,
  input  owtr_pkg::owtr_cfg_t   cfg,
  output owtr_pkg::owtr_result_t result
);
  import owtr_pkg::*;

  localparam int BW = $clog2(READ_BITS + 1);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_R1_LOW  = 4'd1;
  localparam logic [3:0] PH_R1_REL  = 4'd2;
  localparam logic [3:0] PH_W_SKIP1 = 4'd3;
  localparam logic [3:0] PH_W_CONV  = 4'd4;
  localparam logic [3:0] PH_WAIT    = 4'd5;
  localparam logic [3:0] PH_R2_LOW  = 4'd6;
  localparam logic [3:0] PH_R2_REL  = 4'd7;
  localparam logic [3:0] PH_W_SKIP2 = 4'd8;
  localparam logic [3:0] PH_W_READ  = 4'd9;
  localparam logic [3:0] PH_READ    = 4'd10;

  logic [3:0]    phase, phase_next;
  logic [19:0]   slot_timer, slot_timer_next, timer_inc;
  logic [BW-1:0] bit_count, bit_count_next, bit_inc;
  logic [7:0]    tx_shift, tx_shift_next;
  logic [15:0]   rx_shift, rx_shift_next;
  logic          presence_flag, presence_flag_next;
  logic [15:0]   result_word, result_word_next;
  logic          done;
  logic          drive;
  logic [15:0]   magnitude;

  assign timer_inc = slot_timer + 20'd1;
  assign bit_inc   = bit_count + BW'(1);

  always_comb begin
    phase_next         = phase;
    slot_timer_next    = slot_timer;
    bit_count_next     = bit_count;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    presence_flag_next = presence_flag;
    result_word_next   = result_word;
    done               = 1'b0;
    if (cmd) begin
      if (phase == PH_IDLE) begin
        phase_next      = PH_R1_LOW;
        slot_timer_next = '0;
        bit_count_next  = '0;
        rx_shift_next   = '0;
      end
    end else if (phase != PH_IDLE) begin
      slot_timer_next = timer_inc;
      unique case (phase)
        PH_R1_LOW, PH_R2_LOW: begin
          if (timer_inc >= RESET_LOW_US) begin
            phase_next      = (phase == PH_R1_LOW) ? PH_R1_REL : PH_R2_REL;
            slot_timer_next = '0;
          end
        end
        PH_R1_REL, PH_R2_REL: begin
          if (timer_inc >= RESET_REL_US) begin
            if (phase == PH_R1_REL) begin
              presence_flag_next = ~bus_level;
              phase_next         = PH_W_SKIP1;
            end else begin
              phase_next = PH_W_SKIP2;
            end
            tx_shift_next   = cfg.skip_rom_command;
            bit_count_next  = '0;
            slot_timer_next = '0;
          end
        end
        PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ: begin
          if (timer_inc >= WSLOT_US) begin
            tx_shift_next   = {1'b0, tx_shift[7:1]};
            bit_count_next  = bit_inc;
            slot_timer_next = '0;
            if (bit_inc >= BW'(8)) begin
              bit_count_next = '0;
              priority if (phase == PH_W_SKIP1) begin
                phase_next    = PH_W_CONV;
                tx_shift_next = cfg.convert_command;
              end else if (phase == PH_W_SKIP2) begin
                phase_next    = PH_W_READ;
                tx_shift_next = cfg.read_command;
              end else if (phase == PH_W_CONV) begin
                phase_next = PH_WAIT;
              end else begin
                phase_next    = PH_READ;
                rx_shift_next = '0;
              end
            end
          end
        end
        PH_WAIT: begin
          // wait length is read live, so a rewrite applies at once
          if (timer_inc >= cfg.conversion_wait_us) begin
            phase_next      = PH_R2_LOW;
            slot_timer_next = '0;
          end
        end
        PH_READ: begin
          if (timer_inc == R_SAMPLE_US) begin
            rx_shift_next = {bus_level, rx_shift[15:1]};
          end
          if (timer_inc >= RSLOT_US) begin
            bit_count_next  = bit_inc;
            slot_timer_next = '0;
            if (bit_inc >= BW'(READ_BITS)) begin
              result_word_next = rx_shift;
              phase_next       = PH_IDLE;
              bit_count_next   = '0;
              done             = 1'b1;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_next)
      PH_R1_LOW, PH_R2_LOW: drive = 1'b1;
      PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ:
        drive = slot_timer_next < (tx_shift_next[0] ? W1_LOW_US : W0_LOW_US);
      PH_READ: drive = slot_timer_next < R_LOW_US;
      default: drive = 1'b0;
    endcase
  end

  assign magnitude = result_word_next[15] ? 16'(-result_word_next) : result_word_next;

  always_comb begin
    result.drive_low     = drive;
    result.busy_res      = phase_next != PH_IDLE;
    result.done_res      = done;
    result.presence_seen = presence_flag_next;
    result.raw_reading   = result_word_next;
    result.negative      = result_word_next[15];
    result.whole_degrees = magnitude[15:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      slot_timer    <= '0;
      bit_count     <= '0;
      tx_shift      <= '0;
      rx_shift      <= '0;
      presence_flag <= 1'b0;
      result_word   <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      slot_timer    <= slot_timer_next;
      bit_count     <= bit_count_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      presence_flag <= presence_flag_next;
      result_word   <= result_word_next;
    end
  end

endmodule

### hw/rtl/one_wire_temperature_reader.sv
// One-wire temperature reader: ports, config registers, output register and skid.
// An input transfer's result is registered on the output register, or in the skid.
// Throughput: 1 item per cycle while the skid is empty; each item is one sequencer update.
// A stalled output is parked in a one-entry skid, so input stalls only when both are full.
// Reset (rst, synchronous): sequencer idle, config registers at their defaults,
// output empty; raw reading zero until the first reading, presence until first sampled.
module one_wire_temperature_reader #(
  parameter int READ_BITS = owtr_pkg::READ_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [owtr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] bus_level
  input  logic                             s_axis_tuser,  // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_seen,
  // [19:4] raw_reading, [20] negative, [32:21] whole_degrees
  output logic [owtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [7:0]                       cfg_index,
  input  logic [19:0]                      cfg_data
);
  import owtr_pkg::*;

  owtr_cfg_t    cfg;
  owtr_result_t seq_result;
  owtr_result_t out_reg, skid_reg;
  logic         out_valid, skid_valid;
  logic         in_xfer;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~skid_valid;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_rom_command   <= SKIP_ROM_RESET;
      cfg.convert_command    <= CONVERT_RESET;
      cfg.read_command       <= READ_CMD_RESET;
      cfg.conversion_wait_us <= CONV_WAIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SKIP_ROM:  cfg.skip_rom_command   <= cfg_data[7:0];
        CFG_CONVERT:   cfg.convert_command    <= cfg_data[7:0];
        CFG_READ:      cfg.read_command       <= cfg_data[7:0];
        CFG_CONV_WAIT: cfg.conversion_wait_us <= cfg_data;
        default:       cfg.skip_rom_command   <= cfg.skip_rom_command;
      endcase
    end
  end

  owtr_seq #(
    .READ_BITS(READ_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_xfer),
    .cmd      (s_axis_tuser),
    .bus_level(s_axis_tdata[0]),
    .cfg      (cfg),
    .result   (seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_reg <= skid_valid ? skid_reg : seq_result;
    end else if (in_xfer) begin
      skid_reg <= seq_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_reg.whole_degrees, out_reg.negative, out_reg.raw_reading,
                          out_reg.presence_seen, out_reg.done_res, out_reg.busy_res,
                          out_reg.drive_low};

endmodule

### hw/rtl/owtr_checker.sv
// Port-level checks for the one-wire temperature reader, bound to the top level.
module owtr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [owtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import owtr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // input only backs up when a result is waiting on the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // completion returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("done while still busy");

  // bus is only pulled low during a sequence
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("bus driven while idle");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[20] == m_axis_tdata[19])
    else $error("sign flag does not match raw reading");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### tb/tb_one_wire_temperature_reader.sv
`timescale 1ns / 100ps
// Testbench for the one-wire temperature reader: predicted bus and reading outputs checked per transfer.
module tb_one_wire_temperature_reader;
  import owtr_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RST1_LOW,
    SEQ_RST1_REL,
    SEQ_WR_SKIP1,
    SEQ_WR_CONVERT,
    SEQ_CONV_WAIT,
    SEQ_RST2_LOW,
    SEQ_RST2_REL,
    SEQ_WR_SKIP2,
    SEQ_WR_READ,
    SEQ_READ_SLOTS
  } seq_phase_e;

  // Tracks the bus sequencer and holds the outputs it should produce, oldest first.
  class reading_scoreboard;
    owtr_cfg_t    regs;
    seq_phase_e   phase;
    logic [19:0]  slot_timer;
    logic [4:0]   bit_count;
    logic [7:0]   tx_byte;
    logic [15:0]  rx_word;
    logic         presence;
    logic [15:0]  last_reading;
    owtr_result_t expected_outputs[$];
    int unsigned  mismatches;

    function new();
      regs.skip_rom_command   = SKIP_ROM_RESET;
      regs.convert_command    = CONVERT_RESET;
      regs.read_command       = READ_CMD_RESET;
      regs.conversion_wait_us = CONV_WAIT_RESET;
      phase        = SEQ_IDLE;
      slot_timer   = '0;
      bit_count    = '0;
      tx_byte      = '0;
      rx_word      = '0;
      presence     = 1'b0;
      last_reading = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [7:0] index, logic [19:0] value);
      case (index)
        CFG_SKIP_ROM:  regs.skip_rom_command = value[7:0];
        CFG_CONVERT:   regs.convert_command = value[7:0];
        CFG_READ:      regs.read_command = value[7:0];
        CFG_CONV_WAIT: regs.conversion_wait_us = value;
        default: ;
      endcase
    endfunction

    function void load_byte(seq_phase_e nxt_phase, logic [7:0] value);
      phase      = nxt_phase;
      tx_byte    = value;
      bit_count  = '0;
      slot_timer = '0;
    endfunction

    // One microsecond of sequencer time; returns 1 when the reading completes.
    function bit advance_slot(logic level);
      slot_timer = slot_timer + 20'd1;
      case (phase)
        SEQ_RST1_LOW: begin
          if (slot_timer >= RESET_LOW_US) begin
            phase = SEQ_RST1_REL;
            slot_timer = '0;
          end
        end
        SEQ_RST2_LOW: begin
          if (slot_timer >= RESET_LOW_US) begin
            phase = SEQ_RST2_REL;
            slot_timer = '0;
          end
        end
        SEQ_RST1_REL: begin
          if (slot_timer >= RESET_REL_US) begin
            presence = !level;
            load_byte(SEQ_WR_SKIP1, regs.skip_rom_command);
          end
        end
        SEQ_RST2_REL: begin
          if (slot_timer >= RESET_REL_US) load_byte(SEQ_WR_SKIP2, regs.skip_rom_command);
        end
        SEQ_WR_SKIP1, SEQ_WR_CONVERT, SEQ_WR_SKIP2, SEQ_WR_READ: begin
          if (slot_timer >= WSLOT_US) begin
            tx_byte = tx_byte >> 1;
            bit_count = bit_count + 5'd1;
            slot_timer = '0;
            if (bit_count >= 5'd8) begin
              if (phase == SEQ_WR_SKIP1) begin
                load_byte(SEQ_WR_CONVERT, regs.convert_command);
              end else if (phase == SEQ_WR_SKIP2) begin
                load_byte(SEQ_WR_READ, regs.read_command);
              end else if (phase == SEQ_WR_CONVERT) begin
                phase = SEQ_CONV_WAIT;
                bit_count = '0;
              end else begin
                phase = SEQ_READ_SLOTS;
                bit_count = '0;
                rx_word = '0;
              end
            end
          end
        end
        SEQ_CONV_WAIT: begin
          if (slot_timer >= regs.conversion_wait_us) begin
            phase = SEQ_RST2_LOW;
            slot_timer = '0;
          end
        end
        SEQ_READ_SLOTS: begin
          // LSB first: each sample enters at the top and moves down
          if (slot_timer == R_SAMPLE_US) rx_word = {level, rx_word[15:1]};
          if (slot_timer >= RSLOT_US) begin
            bit_count = bit_count + 5'd1;
            slot_timer = '0;
            if (bit_count >= 5'(READ_BITS_DEFAULT)) begin
              last_reading = rx_word;
              phase = SEQ_IDLE;
              bit_count = '0;
              return 1'b1;
            end
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_input(logic cmd, logic level);
      owtr_result_t exp;
      logic         done;
      logic [15:0]  mag;
      done = 1'b0;
      if (cmd) begin
        // a start while busy is dropped
        if (phase == SEQ_IDLE) begin
          phase = SEQ_RST1_LOW;
          slot_timer = '0;
          bit_count = '0;
          rx_word = '0;
        end
      end else if (phase != SEQ_IDLE) begin
        done = advance_slot(level);
      end
      case (phase)
        SEQ_RST1_LOW, SEQ_RST2_LOW: exp.drive_low = 1'b1;
        SEQ_WR_SKIP1, SEQ_WR_CONVERT, SEQ_WR_SKIP2, SEQ_WR_READ:
          exp.drive_low = slot_timer < (tx_byte[0] ? W1_LOW_US : W0_LOW_US);
        SEQ_READ_SLOTS: exp.drive_low = slot_timer < R_LOW_US;
        default: exp.drive_low = 1'b0;
      endcase
      mag = last_reading[15] ? 16'(-last_reading) : last_reading;
      exp.busy_res      = phase != SEQ_IDLE;
      exp.done_res      = done;
      exp.presence_seen = presence;
      exp.raw_reading   = last_reading;
      exp.negative      = last_reading[15];
      exp.whole_degrees = mag[15:4];
      expected_outputs.push_back(exp);
    endfunction

    function void flag(string field, logic [15:0] exp_val, logic [15:0] act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, exp_val, act_val);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      owtr_result_t exp;
      owtr_result_t got;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] output transfer with nothing expected", $time);
        return;
      end
      exp = expected_outputs.pop_front();
      got.drive_low     = data[0];
      got.busy_res      = data[1];
      got.done_res      = data[2];
      got.presence_seen = data[3];
      got.raw_reading   = data[19:4];
      got.negative      = data[20];
      got.whole_degrees = data[32:21];
      if (got.drive_low !== exp.drive_low) flag("drive_low", exp.drive_low, got.drive_low);
      if (got.busy_res !== exp.busy_res) flag("busy_res", exp.busy_res, got.busy_res);
      if (got.done_res !== exp.done_res) flag("done_res", exp.done_res, got.done_res);
      if (got.presence_seen !== exp.presence_seen)
        flag("presence_seen", exp.presence_seen, got.presence_seen);
      if (got.raw_reading !== exp.raw_reading) flag("raw_reading", exp.raw_reading, got.raw_reading);
      if (got.negative !== exp.negative) flag("negative", exp.negative, got.negative);
      if (got.whole_degrees !== exp.whole_degrees)
        flag("whole_degrees", exp.whole_degrees, got.whole_degrees);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_index = '0;
  logic [19:0]            cfg_data = '0;

  reading_scoreboard sb = new();

  // bus stimulus steering: presence answer and the word shifted in during read slots
  bit          steer_bus;
  bit          want_present;
  logic [15:0] target_word;
  bit          sender_calm;
  bit          receiver_calm;

  always #4 clk = ~clk;

  one_wire_temperature_reader u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  task automatic send_item(logic cmd, logic level);
    int unsigned gap;
    if ($urandom_range(0, 199) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, level};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(cmd, level);
  endtask

  task automatic tick_item();
    logic        level;
    logic [19:0] t_next;
    t_next = sb.slot_timer + 20'd1;
    level = 1'($urandom_range(0, 1));
    if (steer_bus) begin
      if (sb.phase == SEQ_RST1_REL && t_next >= RESET_REL_US) level = !want_present;
      if (sb.phase == SEQ_READ_SLOTS && t_next == R_SAMPLE_US)
        level = target_word[sb.bit_count[3:0]];
    end
    send_item(1'b0, level);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_outputs.size() != 0);
  endtask

  task automatic write_reg(logic [7:0] index, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0]  skip_cmd;
    logic [7:0]  conv_cmd;
    logic [7:0]  read_cmd;
    logic [19:0] wait_us;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ticks while idle under the reset settings
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    drain();
    // longest conversion wait: only accepted here, never run through
    write_reg(CFG_CONV_WAIT, 20'hFFFFF);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);

    // one full reading (several thousand ticks): zero wait, most negative word
    drain();
    skip_cmd     = 8'($urandom_range(0, 255));
    conv_cmd     = 8'($urandom_range(0, 255));
    read_cmd     = 8'($urandom_range(0, 255));
    wait_us      = '0;
    target_word  = 16'h8000;
    want_present = 1'b1;
    steer_bus    = 1'b1;
    write_reg(CFG_SKIP_ROM, {12'd0, skip_cmd});
    write_reg(CFG_CONVERT, {12'd0, conv_cmd});
    write_reg(CFG_READ, {12'd0, read_cmd});
    write_reg(CFG_CONV_WAIT, wait_us);

    repeat ($urandom_range(0, 4)) send_item(1'b0, 1'($urandom_range(0, 1)));
    send_item(1'b1, 1'($urandom_range(0, 1)));
    send_item(1'b1, 1'b0);  // start while busy
    while (sb.phase != SEQ_IDLE) begin
      if ($urandom_range(0, 63) == 0) send_item(1'b1, 1'($urandom_range(0, 1)));
      else tick_item();
      if ($urandom_range(0, 2999) == 0) drain();
    end
    repeat (3) send_item(1'b0, 1'($urandom_range(0, 1)));

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // output side: random stalls, one check per transfer
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 199) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### one_wire_temperature_reader.f
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_seq.sv
hw/rtl/one_wire_temperature_reader.sv
hw/rtl/owtr_checker.sv
tb/tb_one_wire_temperature_reader.sv
